// ----- rtl/dpvc_pkg.sv -----
package dpvc_pkg;

  localparam int TEMP_W    = 11;
  localparam int HUM_W     = 10;
  localparam int DEW_W     = 11;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  localparam int LOG_DEPTH = 1024;
  localparam int LOG_IDX_W = $clog2(LOG_DEPTH);
  localparam int LOG_W     = 20;

  // Shared restoring divider: two quotient bits per cycle.
  localparam int DIV_NW    = 40;
  localparam int DIV_DW    = 24;
  localparam int DIV_STEPS = DIV_NW / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam int V_W = 22;

  typedef enum logic [2:0] {
    RSN_NONE    = 3'd0,
    RSN_GOOD    = 3'd1,
    RSN_NO_DATA = 3'd2,
    RSN_DEW     = 3'd3,
    RSN_T_IN    = 3'd4,
    RSN_T_OUT   = 3'd5,
    RSN_HUM     = 3'd6
  } reason_t;

  typedef enum logic [2:0] {
    REG_DELTA_DEW_MIN    = 3'd0,
    REG_DELTA_DEW_HYST   = 3'd1,
    REG_TEMP_INSIDE_MIN  = 3'd2,
    REG_TEMP_OUTSIDE_MIN = 3'd3,
    REG_TEMP_HYST        = 3'd4,
    REG_HUM_INSIDE_MIN   = 3'd5,
    REG_HUM_INSIDE_HYST  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [8:0]  delta_dew_min;
    logic        [6:0]  delta_dew_hyst;
    logic signed [10:0] temp_inside_min;
    logic signed [10:0] temp_outside_min;
    logic        [6:0]  temp_hyst;
    logic        [9:0]  hum_inside_min;
    logic        [7:0]  hum_inside_hyst;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP1,
    OP_STEP,
    OP_PREP2,
    OP_PREP3,
    OP_FIN,
    OP_DECIDE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   side;
  } dp_cmd_t;

  typedef struct packed {
    logic side_ok;
    logic last_step;
  } dp_stat_t;

  typedef logic signed [LOG_W-1:0] log_tab_t [LOG_DEPTH];

  // Integer log2 with 24 fraction bits, by repeated squaring of the mantissa.
  function automatic longint log2_q24(longint unsigned n);
    int k;
    longint unsigned m;
    longint r;
    k = 0;
    for (int j = 1; j < 63; j++) begin
      if ((n >> j) != 0) k = j;
    end
    m = n << (30 - k);
    r = longint'(k) <<< 24;
    for (int b = 23; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r = r + (64'sd1 <<< b);
      end
    end
    return r;
  endfunction

  function automatic log_tab_t build_log_tab();
    log_tab_t t;
    longint lden;
    longint d;
    longint p;
    longint e;
    lden = log2_q24(longint'(LOG_DEPTH) * 1000);
    for (int i = 0; i < LOG_DEPTH; i++) begin
      d = log2_q24(longint'(i + 1) * 1024) - lden;
      p = d * 64'sd1292913987;
      if (p >= 0) e = (p + (64'sd1 <<< 39)) >>> 40;
      else e = -((-p + (64'sd1 <<< 39)) >>> 40);
      t[i] = LOG_W'(e);
    end
    return t;
  endfunction

  // log10 of relative humidity in Q16, one entry per humidity step.
  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

// ----- rtl/dpvc_regs.sv -----
module dpvc_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dpvc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [dpvc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [dpvc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output dpvc_pkg::cfg_t                 cfg
);
  import dpvc_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delta_dew_min    <= 9'sd50;
      cfg.delta_dew_hyst   <= 7'd10;
      cfg.temp_inside_min  <= 11'sd100;
      cfg.temp_outside_min <= -11'sd100;
      cfg.temp_hyst        <= 7'd10;
      cfg.hum_inside_min   <= 10'd650;
      cfg.hum_inside_hyst  <= 8'd50;
    end else if (wr) begin
      case (idx)
        REG_DELTA_DEW_MIN:    cfg.delta_dew_min    <= pwdata[8:0];
        REG_DELTA_DEW_HYST:   cfg.delta_dew_hyst   <= pwdata[6:0];
        REG_TEMP_INSIDE_MIN:  cfg.temp_inside_min  <= pwdata[10:0];
        REG_TEMP_OUTSIDE_MIN: cfg.temp_outside_min <= pwdata[10:0];
        REG_TEMP_HYST:        cfg.temp_hyst        <= pwdata[6:0];
        REG_HUM_INSIDE_MIN:   cfg.hum_inside_min   <= pwdata[9:0];
        REG_HUM_INSIDE_HYST:  cfg.hum_inside_hyst  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DELTA_DEW_MIN:    prdata = CFG_DATA_W'(cfg.delta_dew_min);
      REG_DELTA_DEW_HYST:   prdata = CFG_DATA_W'(cfg.delta_dew_hyst);
      REG_TEMP_INSIDE_MIN:  prdata = CFG_DATA_W'(cfg.temp_inside_min);
      REG_TEMP_OUTSIDE_MIN: prdata = CFG_DATA_W'(cfg.temp_outside_min);
      REG_TEMP_HYST:        prdata = CFG_DATA_W'(cfg.temp_hyst);
      REG_HUM_INSIDE_MIN:   prdata = CFG_DATA_W'(cfg.hum_inside_min);
      REG_HUM_INSIDE_HYST:  prdata = CFG_DATA_W'(cfg.hum_inside_hyst);
      default:              prdata = '0;
    endcase
  end

endmodule

// ----- rtl/dpvc_ctrl.sv -----
module dpvc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  dpvc_pkg::dp_stat_t stat,
  output dpvc_pkg::dp_cmd_t  cmd
);
  import dpvc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_P1, ST_D1, ST_P2, ST_P3, ST_D2, ST_FIN, ST_DEC
  } state_t;

  state_t state;
  logic   side;
  logic   slot_free;

  assign s_tready  = (state == ST_IDLE);
  assign slot_free = !m_tvalid || m_tready;

  always_comb begin
    cmd.side = side;
    case (state)
      ST_IDLE: cmd.op = s_tvalid ? OP_LOAD : OP_NONE;
      ST_P1:   cmd.op = stat.side_ok ? OP_PREP1 : OP_NONE;
      ST_D1:   cmd.op = OP_STEP;
      ST_P2:   cmd.op = OP_PREP2;
      ST_P3:   cmd.op = OP_PREP3;
      ST_D2:   cmd.op = OP_STEP;
      ST_FIN:  cmd.op = OP_FIN;
      ST_DEC:  cmd.op = slot_free ? OP_DECIDE : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      side     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_DEC && slot_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            side  <= 1'b0;
            state <= ST_P1;
          end
        end
        ST_P1:   state <= stat.side_ok ? ST_D1 : ST_FIN;
        ST_D1:   if (stat.last_step) state <= ST_P2;
        ST_P2:   state <= ST_P3;
        ST_P3:   state <= ST_D2;
        ST_D2:   if (stat.last_step) state <= ST_FIN;
        ST_FIN: begin
          if (side) begin
            state <= ST_DEC;
          end else begin
            side  <= 1'b1;
            state <= ST_P1;
          end
        end
        ST_DEC: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/dpvc_datapath.sv -----
module dpvc_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic [47:0]        s_tdata,
  input  dpvc_pkg::cfg_t     cfg,
  input  dpvc_pkg::dp_cmd_t  cmd,
  output dpvc_pkg::dp_stat_t stat,
  output logic [31:0]        m_tdata
);
  import dpvc_pkg::*;

  // Captured reading.
  logic signed [TEMP_W-1:0] ti, to;
  logic [HUM_W-1:0]         hi, ho;
  logic                     vi_f, vo_f;

  // Working values.
  logic signed [LOG_W-1:0]  log_q;
  logic                     neg;
  logic                     tpos;
  logic signed [V_W-1:0]    v;
  logic                     den_bad;
  logic signed [DEW_W-1:0]  dew_in, dew_out;

  // Divider.
  logic [DIV_NW-1:0]        div_nq;
  logic [DIV_DW-1:0]        div_rem;
  logic [DIV_DW-1:0]        div_d;
  logic [DIV_CNT_W-1:0]     div_cnt;

  // Result.
  logic                     fan_state;
  reason_t                  last_reason;
  logic signed [DEW_W-1:0]  res_dew_in, res_dew_out;

  logic vi, vo;
  assign vi = vi_f && (hi != '0);
  assign vo = vo_f && (ho != '0);
  assign stat.side_ok   = cmd.side ? vo : vi;
  assign stat.last_step = (div_cnt == DIV_CNT_W'(1));

  assign m_tdata = {6'd0, res_dew_out, res_dew_in, last_reason, fan_state};

  // First division setup: a*t / (b+t) in Q16, and the log table lookup.
  localparam int HP_W = HUM_W + LOG_IDX_W + 1;
  logic signed [TEMP_W-1:0] t_sel;
  logic [HUM_W-1:0]         h_sel;
  logic                     t_pos;
  logic [6:0]               a10;
  logic signed [12:0]       b10;
  logic [TEMP_W:0]          t_mag;
  logic [DIV_NW-1:0]        num1;
  logic signed [17:0]       den1;
  logic [HP_W-1:0]          hp;
  logic [HP_W-1:0]          hsh;
  logic [LOG_IDX_W-1:0]     lidx;

  always_comb begin
    t_sel = cmd.side ? to : ti;
    h_sel = cmd.side ? ho : hi;
    t_pos = !t_sel[TEMP_W-1];
    a10   = t_pos ? 7'd75 : 7'd76;
    b10   = t_pos ? 13'sd2373 : 13'sd2407;
    t_mag = t_pos ? {1'b0, t_sel} : (TEMP_W+1)'(-{t_sel[TEMP_W-1], t_sel});
    num1  = DIV_NW'({17'(a10) * 17'(t_mag), 16'd0});
    den1  = 18'sd10 * 18'(b10 + 13'(t_sel));
    hp    = HP_W'(h_sel) * HP_W'(LOG_DEPTH) - HP_W'(1);
    hsh   = hp >> 10;
    lidx  = (hsh >= HP_W'(LOG_DEPTH)) ? LOG_IDX_W'(LOG_DEPTH - 1) : hsh[LOG_IDX_W-1:0];
  end

  // Second division setup: 10*b*v / (a*65536 - 10*v), with a and b scaled by ten.
  logic [V_W-1:0]           v_mag;
  logic [14:0]              b100;
  logic [DIV_NW-1:0]        num2;
  logic signed [27:0]       den2;
  logic [6:0]               a10_v;

  always_comb begin
    a10_v = tpos ? 7'd75 : 7'd76;
    b100  = tpos ? 15'd23730 : 15'd24070;
    v_mag = v[V_W-1] ? V_W'(-v) : V_W'(v);
    num2  = DIV_NW'(b100) * DIV_NW'(v_mag);
    den2  = 28'(signed'({1'b0, a10_v, 16'd0})) - 28'sd10 * 28'(v);
  end

  // Two restoring steps per cycle.
  logic [DIV_NW-1:0] nq_s;
  logic [DIV_DW-1:0] rem_s;
  logic [DIV_DW:0]   rt;

  always_comb begin
    nq_s  = div_nq;
    rem_s = div_rem;
    for (int k = 0; k < 2; k++) begin
      rt   = {rem_s, nq_s[DIV_NW-1]};
      nq_s = {nq_s[DIV_NW-2:0], 1'b0};
      if (rt >= {1'b0, div_d}) begin
        rt      = rt - {1'b0, div_d};
        nq_s[0] = 1'b1;
      end
      rem_s = rt[DIV_DW-1:0];
    end
  end

  // Signed quotient, saturated to the dew point range.
  logic signed [V_W-1:0]   q1;
  logic signed [DEW_W-1:0] dew_fin;

  always_comb begin
    q1 = neg ? -V_W'(div_nq) : V_W'(div_nq);
    if (!stat.side_ok) dew_fin = '0;
    else if (den_bad) dew_fin = DEW_W'(850);
    else if (neg) dew_fin = (div_nq > DIV_NW'(1000)) ? -DEW_W'(1000) : -DEW_W'(div_nq);
    else dew_fin = (div_nq > DIV_NW'(850)) ? DEW_W'(850) : DEW_W'(div_nq);
  end

  // Fan decision.
  logic signed [13:0] delta, thr_dew_on, thr_ti_on, thr_to_on;
  logic signed [13:0] ti_x, to_x, h_x, thr_h_on;
  logic               all_on;

  always_comb begin
    delta      = 14'(dew_in) - 14'(dew_out);
    thr_dew_on = 14'(cfg.delta_dew_min) + 14'(signed'({1'b0, cfg.delta_dew_hyst}));
    thr_ti_on  = 14'(cfg.temp_inside_min) + 14'(signed'({1'b0, cfg.temp_hyst}));
    thr_to_on  = 14'(cfg.temp_outside_min) + 14'(signed'({1'b0, cfg.temp_hyst}));
    thr_h_on   = 14'(signed'({1'b0, cfg.hum_inside_min}))
               + 14'(signed'({1'b0, cfg.hum_inside_hyst}));
    ti_x       = 14'(ti);
    to_x       = 14'(to);
    h_x        = 14'(signed'({1'b0, hi}));
    all_on     = (delta > thr_dew_on) && (ti_x > thr_ti_on) && (to_x > thr_to_on)
              && (h_x > thr_h_on);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt     <= '0;
      fan_state   <= 1'b0;
      last_reason <= RSN_NONE;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          ti   <= s_tdata[10:0];
          hi   <= s_tdata[20:11];
          vi_f <= s_tdata[21];
          to   <= s_tdata[32:22];
          ho   <= s_tdata[42:33];
          vo_f <= s_tdata[43];
        end
        OP_PREP1: begin
          log_q   <= LOG_TAB[lidx];
          neg     <= !t_pos;
          tpos    <= t_pos;
          div_nq  <= num1 + DIV_NW'(den1 >>> 1);
          div_d   <= DIV_DW'(den1);
          div_rem <= '0;
          div_cnt <= DIV_CNT_W'(DIV_STEPS);
        end
        OP_STEP: begin
          div_nq  <= nq_s;
          div_rem <= rem_s;
          div_cnt <= div_cnt - DIV_CNT_W'(1);
        end
        OP_PREP2: v <= q1 + V_W'(log_q);
        OP_PREP3: begin
          neg     <= v[V_W-1];
          den_bad <= (den2 <= 28'sd0);
          div_nq  <= num2 + DIV_NW'(den2[DIV_DW-1:1]);
          div_d   <= den2[DIV_DW-1:0];
          div_rem <= '0;
          div_cnt <= DIV_CNT_W'(DIV_STEPS);
        end
        OP_FIN: begin
          if (cmd.side) dew_out <= dew_fin;
          else dew_in <= dew_fin;
        end
        OP_DECIDE: begin
          res_dew_in  <= dew_in;
          res_dew_out <= dew_out;
          if (!vi || !vo) begin
            fan_state   <= 1'b0;
            last_reason <= RSN_NO_DATA;
          end else if (all_on) begin
            fan_state   <= 1'b1;
            last_reason <= RSN_GOOD;
          end else if (fan_state) begin
            if (delta < 14'(cfg.delta_dew_min)) begin
              fan_state   <= 1'b0;
              last_reason <= RSN_DEW;
            end else if (ti_x < 14'(cfg.temp_inside_min)) begin
              fan_state   <= 1'b0;
              last_reason <= RSN_T_IN;
            end else if (to_x < 14'(cfg.temp_outside_min)) begin
              fan_state   <= 1'b0;
              last_reason <= RSN_T_OUT;
            end else if (h_x < 14'(signed'({1'b0, cfg.hum_inside_min}))) begin
              fan_state   <= 1'b0;
              last_reason <= RSN_HUM;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/dew_point_ventilation_control.sv -----
// Dew point ventilation controller.
// Input beats on s_* carry one set of inside and outside temperature and
// humidity readings; each accepted beat yields exactly one result beat on m_*
// with the fan drive, a reason code and both dew points in tenths of a degree.
// Thresholds and hysteresis values are written through the APB port.
// One item is handled at a time. Each dew point takes two passes through a
// shared restoring divider that retires two quotient bits per cycle; an
// item with both sides valid runs both passes for each side before its result
// beat, and the next beat is taken only once the block is idle again.
// A side without data skips its divisions.
// s_tready is high only while the block is idle, which includes the time a
// finished result waits in the output register.
// When the receiver stalls, the result is held in the output register and a
// new item is still accepted; its result waits until the register is free.
// Reset turns the fan off, clears the reason code and loads the default
// thresholds; the logarithm table is a constant ROM and needs no fill.
module dew_point_ventilation_control (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [10:0] temp_inside, [20:11] hum_inside, [21] inside_valid,
  // [32:22] temp_outside, [42:33] hum_outside, [43] outside_valid
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] fan_on, [3:1] reason_code, [14:4] dew_inside, [25:15] dew_outside
  output logic [31:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dpvc_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  dpvc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  dpvc_ctrl u_ctrl (
    .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .stat, .cmd
  );

  dpvc_datapath u_dp (
    .clk, .rst, .s_tdata, .cfg, .cmd, .stat, .m_tdata
  );

endmodule
